// ===== sv/set_assoc_cache_tag_controller_top_assert.svh =====
// Assertion macros used by the cache tag controller checker.
`ifndef SET_ASSOC_CACHE_TAG_CONTROLLER_TOP_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_CONTROLLER_TOP_ASSERT_SVH

// Implication checked in the same cycle.
`define SACT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cache tag controller check failed");

// Implication checked in the next cycle.
`define SACT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cache tag controller check failed");

`endif

// ===== sv/sact_pkg.sv =====
// Types and constants of the set-associative cache tag controller.
package sact_pkg;

    localparam int ADDR_W     = 48;
    localparam int STAMP_W    = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;

    // Command codes.
    localparam logic [1:0] CMD_ACCESS = 2'd0;
    localparam logic [1:0] CMD_PROBE  = 2'd1;
    localparam logic [1:0] CMD_FILL   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_MODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_BACK     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOCATE = 3'd5;

    typedef struct packed {
        logic [1:0]        command;
        logic              is_write;
        logic [ADDR_W-1:0] address;
    } req_word_t;

    typedef struct packed {
        logic              hit;
        logic              bypassed;
        logic              memory_read;
        logic              memory_write;
        logic              evicted;
        logic              dirty_evicted;
        logic [ADDR_W-1:0] evicted_block;
    } rsp_word_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic read;
        logic scan;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic scan_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

// ===== sv/sact_ctrl.sv =====
// Sequencer of the cache tag controller: clear pass, set read, way scan, commit.
module sact_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  sact_pkg::ctrl_sts_t sts,
    output sact_pkg::ctrl_cmd_t cmd
);
    import sact_pkg::*;

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                    state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/sact_datapath.sv =====
// Datapath of the cache tag controller: set memories, way scan and result register.
module sact_datapath #(
    parameter int MAX_SETS  = 256,
    parameter int MAX_WAYS  = 8,
    parameter int ADDR_BITS = 48
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [sact_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sact_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  sact_pkg::req_word_t                  req,
    input  sact_pkg::ctrl_cmd_t                  cmd,
    output sact_pkg::ctrl_sts_t                  sts,
    output logic                                 rsp_valid,
    input  logic                                 rsp_ready,
    output sact_pkg::rsp_word_t                  rsp
);
    import sact_pkg::*;

    localparam int AW       = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int SET_BITS = $clog2(MAX_SETS);
    localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int IB_MAX   = (SET_BITS > 15) ? 15 : SET_BITS;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WN_W     = $clog2(MAX_WAYS + 1);

    // Configuration registers.
    logic [3:0] offset_bits_reg, index_bits_reg, ways_in_use_reg;
    logic       replace_mode_reg, write_back_reg, write_allocate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg    <= 4'd6;
            index_bits_reg     <= 4'd6;
            ways_in_use_reg    <= 4'd4;
            replace_mode_reg   <= 1'b0;
            write_back_reg     <= 1'b1;
            write_allocate_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OFFSET_BITS:    offset_bits_reg    <= cfg_data;
                CFG_INDEX_BITS:     index_bits_reg     <= cfg_data;
                CFG_WAYS_IN_USE:    ways_in_use_reg    <= cfg_data;
                CFG_REPLACE_MODE:   replace_mode_reg   <= cfg_data[0];
                CFG_WRITE_BACK:     write_back_reg     <= cfg_data[0];
                CFG_WRITE_ALLOCATE: write_allocate_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Item registers and the event counter.
    logic [1:0]         command_reg;
    logic               is_write_reg;
    logic [AW-1:0]      addr_reg;
    logic [STAMP_W-1:0] event_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            command_reg  <= req.command;
            is_write_reg <= req.is_write;
            addr_reg     <= req.address[AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            event_reg <= '0;
        else if (cmd.load && (req.command != CMD_UNUSED))
            event_reg <= event_reg + STAMP_W'(1);
    end

    // Address split into block, set and tag.
    logic [3:0]       ib_eff;
    logic [AW-1:0]    blk, tag;
    logic [SET_W:0]   set_one;
    logic [SET_W-1:0] set_mask, set_idx;
    logic [WN_W-1:0]  nw;

    always_comb
    begin
        ib_eff   = (int'(index_bits_reg) > IB_MAX) ? 4'(IB_MAX) : index_bits_reg;
        blk      = addr_reg >> offset_bits_reg;
        tag      = blk >> ib_eff;
        set_one  = (SET_W + 1)'(1) << ib_eff;
        set_mask = set_one[SET_W-1:0] - SET_W'(1);
        set_idx  = blk[SET_W-1:0] & set_mask;
        if (ways_in_use_reg == 4'd0)
            nw = WN_W'(1);
        else if (int'(ways_in_use_reg) > MAX_WAYS)
            nw = WN_W'(MAX_WAYS);
        else
            nw = WN_W'(ways_in_use_reg);
    end

    // Set memories, one row per set holding every way.
    logic [MAX_WAYS-1:0]                valid_mem [MAX_SETS];
    logic [MAX_WAYS-1:0]                dirty_mem [MAX_SETS];
    logic [MAX_WAYS-1:0][AW-1:0]        tag_mem   [MAX_SETS];
    logic [MAX_WAYS-1:0][AW-1:0]        block_mem [MAX_SETS];
    logic [MAX_WAYS-1:0][STAMP_W-1:0]   use_mem   [MAX_SETS];
    logic [MAX_WAYS-1:0][STAMP_W-1:0]   fill_mem  [MAX_SETS];

    logic [MAX_WAYS-1:0]                rd_valid, rd_dirty, wr_valid, wr_dirty;
    logic [MAX_WAYS-1:0][AW-1:0]        rd_tag, rd_block, wr_tag, wr_block;
    logic [MAX_WAYS-1:0][STAMP_W-1:0]   rd_use, rd_fill, wr_use, wr_fill;

    logic [SET_W-1:0] clr_reg;

    // Clearing pass counter after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (cmd.clear)
            clr_reg <= clr_reg + SET_W'(1);
    end

    // Valid and dirty rows: cleared by the sweep, written on commit.
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            valid_mem[clr_reg] <= '0;
            dirty_mem[clr_reg] <= '0;
        end
        else if (cmd.commit)
        begin
            valid_mem[set_idx] <= wr_valid;
            dirty_mem[set_idx] <= wr_dirty;
        end
        if (cmd.read)
        begin
            rd_valid <= valid_mem[set_idx];
            rd_dirty <= dirty_mem[set_idx];
        end
    end

    // Tag, block and stamp rows.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            tag_mem[set_idx]   <= wr_tag;
            block_mem[set_idx] <= wr_block;
            use_mem[set_idx]   <= wr_use;
            fill_mem[set_idx]  <= wr_fill;
        end
        if (cmd.read)
        begin
            rd_tag   <= tag_mem[set_idx];
            rd_block <= block_mem[set_idx];
            rd_use   <= use_mem[set_idx];
            rd_fill  <= fill_mem[set_idx];
        end
    end

    // Way scan: one way per cycle for hit, first invalid and oldest stamp.
    logic [WAY_W-1:0]   way_reg, hit_way_reg, inv_way_reg, best_way_reg;
    logic               hit_found_reg, inv_found_reg;
    logic [STAMP_W-1:0] best_stamp_reg, cur_stamp;
    logic               lookup;

    assign lookup    = (command_reg == CMD_ACCESS) || (command_reg == CMD_PROBE);
    assign cur_stamp = replace_mode_reg ? rd_fill[way_reg] : rd_use[way_reg];

    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            way_reg       <= '0;
            hit_found_reg <= 1'b0;
            inv_found_reg <= 1'b0;
        end
        else if (cmd.scan)
        begin
            way_reg <= way_reg + WAY_W'(1);
            if (lookup && !hit_found_reg && rd_valid[way_reg] && (rd_tag[way_reg] == tag))
            begin
                hit_found_reg <= 1'b1;
                hit_way_reg   <= way_reg;
            end
            if (!rd_valid[way_reg] && !inv_found_reg)
            begin
                inv_found_reg <= 1'b1;
                inv_way_reg   <= way_reg;
            end
            if ((way_reg == '0) || (cur_stamp < best_stamp_reg))
            begin
                best_stamp_reg <= cur_stamp;
                best_way_reg   <= way_reg;
            end
        end
    end

    // Outcome of the item and the updated row.
    logic             is_acc, is_fill, hit, bypass, alloc, ev, dev, mwr;
    logic [WAY_W-1:0] vway;
    logic [AW-1:0]    eblk;

    always_comb
    begin
        is_acc  = (command_reg == CMD_ACCESS);
        is_fill = (command_reg == CMD_FILL);
        hit     = lookup && hit_found_reg;
        bypass  = is_acc && !hit && is_write_reg && !write_back_reg && !write_allocate_reg;
        alloc   = !bypass && ((is_acc && !hit) || is_fill);
        vway    = inv_found_reg ? inv_way_reg : best_way_reg;
        ev      = alloc && rd_valid[vway];
        dev     = ev && rd_dirty[vway] && (is_fill || write_back_reg);
        eblk    = ev ? rd_block[vway] : '0;
        mwr     = bypass
                  || (hit && is_acc && is_write_reg && !write_back_reg)
                  || (alloc && is_acc && (dev || (is_write_reg && !write_back_reg)));

        wr_valid = rd_valid;
        wr_dirty = rd_dirty;
        wr_tag   = rd_tag;
        wr_block = rd_block;
        wr_use   = rd_use;
        wr_fill  = rd_fill;
        if (hit)
        begin
            wr_use[hit_way_reg] = event_reg;
            if (is_acc && is_write_reg && write_back_reg)
                wr_dirty[hit_way_reg] = 1'b1;
        end
        if (alloc)
        begin
            wr_valid[vway] = 1'b1;
            wr_dirty[vway] = is_write_reg && write_back_reg;
            wr_tag[vway]   = tag;
            wr_block[vway] = blk;
            wr_use[vway]   = event_reg;
            wr_fill[vway]  = event_reg;
        end
    end

    // Result register.
    logic      rsp_valid_reg;
    rsp_word_t rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.commit)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rsp_reg.hit           <= hit;
            rsp_reg.bypassed      <= bypass;
            rsp_reg.memory_read   <= alloc && is_acc;
            rsp_reg.memory_write  <= mwr;
            rsp_reg.evicted       <= ev;
            rsp_reg.dirty_evicted <= dev;
            rsp_reg.evicted_block <= ADDR_W'(eblk);
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign rsp            = rsp_reg;
    assign sts.clear_last = (clr_reg == SET_W'(MAX_SETS - 1));
    assign sts.scan_last  = ((WN_W'(way_reg) + WN_W'(1)) == nw);
    assign sts.out_free   = !rsp_valid_reg || rsp_ready;

endmodule

// ===== sv/set_assoc_cache_tag_controller_top.sv =====
// Top level of the set-associative cache tag controller.
// Each request word (access, probe, forced fill or unused command) passes through
// these steps from acceptance to the next acceptance: the set row is read from the
// set memories, the ways in use (ways_in_use held to 1..MAX_WAYS) are scanned one way
// per cycle through the single tag and stamp comparator, the row is written back and
// the result register loaded, and the next word is taken in the idle state. The
// result register lets a new request be taken while a finished result still waits;
// the write-back of that next word then stalls until the waiting result word is
// taken. After reset a clearing pass over all MAX_SETS sets resets the valid and
// dirty bits before the first request is taken. Configuration writes take effect at
// once and are to be made only while no word is in flight.
module set_assoc_cache_tag_controller_top #(
    parameter int MAX_SETS  = 256,
    parameter int MAX_WAYS  = 8,
    parameter int ADDR_BITS = 48
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  sact_pkg::req_word_t             req,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output sact_pkg::rsp_word_t             rsp,
    input  logic                            cfg_we,
    input  logic [sact_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sact_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sact_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // Sequencer.
    sact_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath.
    sact_datapath #(
        .MAX_SETS  (MAX_SETS),
        .MAX_WAYS  (MAX_WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// ===== sv/sact_checker.sv =====
// Port-level checker of the cache tag controller and its bind.
`include "set_assoc_cache_tag_controller_top_assert.svh"

module sact_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            req_valid,
    input logic                            req_ready,
    input logic                            rsp_valid,
    input logic                            rsp_ready,
    input sact_pkg::rsp_word_t             rsp
);
    import sact_pkg::*;

    // A stalled result word holds.
    `SACT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
    // The block is busy right after taking a request word.
    `SACT_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
    // A hit neither bypasses nor fetches.
    `SACT_ASSERT_NOW(a_hit_no_fetch, rsp_valid && rsp.hit, !rsp.bypassed && !rsp.memory_read)
    // Without an eviction there is no dirty eviction and no block address.
    `SACT_ASSERT_NOW(a_no_evict_zero, rsp_valid && !rsp.evicted, !rsp.dirty_evicted && (rsp.evicted_block == '0))

endmodule

bind set_assoc_cache_tag_controller_top sact_checker u_sact_checker (.*);

// ===== test/set_assoc_cache_tag_controller_top_test.sv =====
// Self-checking testbench for the set-associative cache tag controller top level.
`timescale 1ns / 100ps

module set_assoc_cache_tag_controller_top_test;
    import sact_pkg::*;

    localparam int N_SETS  = 256;
    localparam int N_WAYS  = 8;
    localparam int N_LINES = N_SETS * N_WAYS;
    localparam int N_RANDOM = 1030;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_word_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_word_t rsp;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    set_assoc_cache_tag_controller_top u_top (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Mirror of the cache directory and its settings.
    logic              dir_valid [N_LINES];
    logic              dir_dirty [N_LINES];
    logic [ADDR_W-1:0] dir_tag   [N_LINES];
    logic [ADDR_W-1:0] dir_block [N_LINES];
    logic [STAMP_W-1:0] dir_used [N_LINES];
    logic [STAMP_W-1:0] dir_filled [N_LINES];
    logic [STAMP_W-1:0] stamp_now;
    logic [3:0] set_offset_bits, set_index_bits, set_ways;
    logic set_fifo, set_write_back, set_write_alloc;

    rsp_word_t pending_rsp [$];
    int mismatch_count;
    int rsp_count;
    logic hold_off;
    logic all_sent;

    // Stimulus table for the directed part.
    typedef struct {
        req_word_t word;
        logic      known;
        rsp_word_t answer;
    } dir_row_t;

    always #6 clk = ~clk;

    // Choose the victim way in a set: first invalid, else oldest stamp.
    function automatic int victim_way(int base, int nw);
        int best;
        logic [STAMP_W-1:0] best_stamp, s;
        best = 0;
        best_stamp = '0;
        for (int w = 0; w < nw; w++)
            if (!dir_valid[base + w])
                return w;
        for (int w = 0; w < nw; w++)
        begin
            s = set_fifo ? dir_filled[base + w] : dir_used[base + w];
            if (w == 0 || s < best_stamp)
            begin
                best_stamp = s;
                best = w;
            end
        end
        return best;
    endfunction

    // Work out the result of one request word and update the mirror.
    function automatic rsp_word_t cache_lookup(req_word_t w);
        rsp_word_t r;
        int ib, nw, base, set_idx, v;
        logic [ADDR_W-1:0] blk, tg;
        logic wr, wb;
        r = '0;
        if (w.command == CMD_UNUSED)
            return r;
        ib = set_index_bits;
        while (ib > 0 && (1 << ib) > N_SETS)
            ib--;
        nw = (set_ways < 1) ? 1 : (set_ways > N_WAYS) ? N_WAYS : set_ways;
        wr = w.is_write;
        wb = set_write_back;
        blk = w.address >> set_offset_bits;
        set_idx = int'(blk & ((48'd1 << ib) - 1));
        tg = blk >> ib;
        base = set_idx * N_WAYS;
        stamp_now = stamp_now + STAMP_W'(1);
        if (w.command != CMD_FILL)
        begin
            for (int i = 0; i < nw; i++)
            begin
                if (dir_valid[base + i] && dir_tag[base + i] == tg)
                begin
                    r.hit = 1'b1;
                    dir_used[base + i] = stamp_now;
                    if (w.command == CMD_ACCESS && wr)
                    begin
                        if (wb)
                            dir_dirty[base + i] = 1'b1;
                        else
                            r.memory_write = 1'b1;
                    end
                    break;
                end
            end
        end
        if (w.command == CMD_ACCESS && !r.hit && wr && !wb && !set_write_alloc)
        begin
            r.bypassed = 1'b1;
            r.memory_write = 1'b1;
        end
        else if ((w.command == CMD_ACCESS && !r.hit) || w.command == CMD_FILL)
        begin
            v = base + victim_way(base, nw);
            r.evicted = dir_valid[v];
            r.dirty_evicted = dir_valid[v] && dir_dirty[v] &&
                              (wb || w.command == CMD_FILL);
            r.evicted_block = dir_valid[v] ? dir_block[v] : '0;
            dir_valid[v] = 1'b1;
            dir_dirty[v] = wr && wb;
            dir_tag[v] = tg;
            dir_block[v] = blk;
            dir_filled[v] = stamp_now;
            dir_used[v] = stamp_now;
            if (w.command == CMD_ACCESS)
            begin
                r.memory_read = 1'b1;
                r.memory_write = r.dirty_evicted || (wr && !wb);
            end
        end
        return r;
    endfunction

    // Register write; only called while the block is idle. The caller drops the enable.
    task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [3:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        case (idx)
            CFG_OFFSET_BITS:    set_offset_bits = val;
            CFG_INDEX_BITS:     set_index_bits = val;
            CFG_WAYS_IN_USE:    set_ways = val;
            CFG_REPLACE_MODE:   set_fifo = val[0];
            CFG_WRITE_BACK:     set_write_back = val[0];
            CFG_WRITE_ALLOCATE: set_write_alloc = val[0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [3:0] ob, logic [3:0] ib, logic [3:0] nw,
                             logic fifo, logic wb, logic wa);
        write_setting(CFG_OFFSET_BITS, ob);
        write_setting(CFG_INDEX_BITS, ib);
        write_setting(CFG_WAYS_IN_USE, nw);
        write_setting(CFG_REPLACE_MODE, {3'b0, fifo});
        write_setting(CFG_WRITE_BACK, {3'b0, wb});
        write_setting(CFG_WRITE_ALLOCATE, {3'b0, wa});
        cfg_we <= 1'b0;
    endtask

    // Offer one word and hold it until the edge at which it is taken.
    task automatic offer_word(req_word_t w);
        req <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // Offer one word, predict its result once taken; valid is dropped by the gap.
    task automatic send_word(req_word_t w);
        offer_word(w);
        pending_rsp.push_back(cache_lookup(w));
        @(negedge clk);
    endtask

    // Idle gap after a word; a zero gap keeps valid high for the next word.
    task automatic random_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
            ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        if (n > 0)
            req_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // Wait until every result has arrived, plus the longest request latency.
    task automatic drain();
        while (pending_rsp.size() != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    function automatic logic [ADDR_W-1:0] random_address();
        logic [ADDR_W-1:0] a;
        a = ADDR_W'({$urandom, $urandom});
        // Mostly a small pool of blocks so that sets fill and lines recur.
        if ($urandom_range(0, 4) != 0)
            a = a & 48'h0000_0000_3FFF;
        return a;
    endfunction

    task automatic random_phase(int count);
        req_word_t w;
        for (int k = 0; k < count; k++)
        begin
            w.command = ($urandom_range(0, 19) == 0) ? CMD_UNUSED :
                        ($urandom_range(0, 5) == 0) ? CMD_PROBE :
                        ($urandom_range(0, 7) == 0) ? CMD_FILL : CMD_ACCESS;
            w.is_write = 1'($urandom_range(0, 1));
            w.address = random_address();
            send_word(w);
            random_gap();
        end
        req_valid <= 1'b0;
    endtask

    // Result checker on the receive side.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word %h", rsp);
            end
            else
            begin
                rsp_word_t e;
                e = pending_rsp.pop_front();
                rsp_count++;
                if (rsp !== e)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("result %0d: expected hit %b byp %b rd %b wr %b ev %b dev %b blk %h",
                                 rsp_count, e.hit, e.bypassed, e.memory_read,
                                 e.memory_write, e.evicted, e.dirty_evicted,
                                 e.evicted_block);
                        $display("result %0d: got      hit %b byp %b rd %b wr %b ev %b dev %b blk %h",
                                 rsp_count, rsp.hit, rsp.bypassed,
                                 rsp.memory_read, rsp.memory_write, rsp.evicted,
                                 rsp.dirty_evicted, rsp.evicted_block);
                    end
                end
            end
        end
    end

    // Receiver readiness with random stalls, and one long hold-off on request.
    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
            rsp_ready <= 1'b0;
        else if ($urandom_range(0, 3) == 0)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= 1'b1;
    end

    initial
    begin
        hold_off = 1'b0;
        wait (all_sent === 1'b0);
        wait (rsp_count >= 300);
        hold_off = 1'b1;
        repeat (200) @(negedge clk);
        hold_off = 1'b0;
    end

    // Run limit.
    initial
    begin
        #30ms;
        $display("** set_assoc_cache_tag_controller_top: FAILED **");
        $finish;
    end

    initial
    begin
        dir_row_t rows [$];
        dir_row_t row;
        rsp_word_t exp_now;
        clk = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        all_sent = 1'b0;
        mismatch_count = 0;
        rsp_count = 0;
        stamp_now = '0;
        set_offset_bits = 4'd6;
        set_index_bits = 4'd6;
        set_ways = 4'd4;
        set_fifo = 1'b0;
        set_write_back = 1'b1;
        set_write_alloc = 1'b1;
        for (int i = 0; i < N_LINES; i++)
        begin
            dir_valid[i] = 1'b0;
            dir_dirty[i] = 1'b0;
            dir_tag[i] = '0;
            dir_block[i] = '0;
            dir_used[i] = '0;
            dir_filled[i] = '0;
        end
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed part under the reset settings; known rows checked literally.
        row.known = 1'b1;
        row.word = '{CMD_ACCESS, 1'b0, 48'h0};
        row.answer = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 48'h0};
        rows.push_back(row);
        row.word = '{CMD_PROBE, 1'b0, 48'h0};
        row.answer = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 48'h0};
        rows.push_back(row);
        row.word = '{CMD_ACCESS, 1'b1, 48'h3F};
        row.answer = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 48'h0};
        rows.push_back(row);
        row.word = '{CMD_UNUSED, 1'b1, 48'hFFFF_FFFF_FFFF};
        row.answer = '0;
        rows.push_back(row);
        row.word = '{CMD_PROBE, 1'b0, 48'hFFFF_FFFF_FFFF};
        rows.push_back(row);
        row.known = 1'b0;
        row.word = '{CMD_ACCESS, 1'b1, 48'hFFFF_FFFF_FFFF};
        rows.push_back(row);
        // Three more blocks of set zero fill the set; the next ones evict dirty lines.
        for (int k = 1; k <= 5; k++)
        begin
            row.word = '{CMD_ACCESS, 1'b1, 48'(k) << 12};
            rows.push_back(row);
        end
        row.word = '{CMD_FILL, 1'b1, 48'h0};
        rows.push_back(row);
        row.word = '{CMD_FILL, 1'b0, 48'h0};
        rows.push_back(row);
        row.word = '{CMD_PROBE, 1'b1, 48'h5000};
        rows.push_back(row);
        row.word = '{CMD_ACCESS, 1'b0, 48'h8000_0000_0000};
        rows.push_back(row);

        @(negedge clk);
        foreach (rows[i])
        begin
            if (rows[i].known)
            begin
                exp_now = cache_lookup(rows[i].word);
                if (exp_now !== rows[i].answer)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("row %0d: expected %h, predictor gives %h",
                                 i, rows[i].answer, exp_now);
                end
                pending_rsp.push_back(exp_now);
                offer_word(rows[i].word);
                @(negedge clk);
            end
            else
                send_word(rows[i].word);
            random_gap();
        end
        req_valid <= 1'b0;
        drain();

        // Write-through without allocation, FIFO, a single way and a single set.
        write_all(4'd0, 4'd0, 4'd1, 1'b1, 1'b0, 1'b0);
        random_phase(60);
        drain();
        // Largest block and set counts, all ways, LRU, write-back.
        write_all(4'd15, 4'd8, 4'd8, 1'b0, 1'b1, 1'b0);
        random_phase(60);
        drain();
        // Out-of-range values: saturated sets and ways, zero ways.
        write_all(4'd3, 4'd15, 4'd0, 1'b1, 1'b1, 1'b1);
        random_phase(40);
        drain();
        write_all(4'd2, 4'd2, 4'd15, 1'b0, 1'b0, 1'b1);
        random_phase(120);
        drain();
        // Small geometry so that evictions are frequent.
        write_all(4'd4, 4'd3, 4'd2, 1'b0, 1'b1, 1'b1);
        random_phase(N_RANDOM - 280);
        // Sender pause until everything has come back.
        drain();
        write_all(4'd12, 4'd4, 4'd3, 1'b1, 1'b0, 1'b1);
        random_phase(30);
        all_sent = 1'b1;
        drain();
        wait (hold_off == 1'b0);
        drain();

        if (mismatch_count == 0)
            $display("** set_assoc_cache_tag_controller_top: PASSED **");
        else
            $display("** set_assoc_cache_tag_controller_top: FAILED **");
        $finish;
    end
endmodule
